[design/wcpt_pkg.sv]
// shared types, codes and defaults for the word count posting table
package wcpt_pkg;

	localparam int TABLE_DEPTH_DEF       = 256;
	localparam int SOURCES_PER_ENTRY_DEF = 16;
	localparam int TOP_LIMIT_DEF         = 16;
	localparam int KEY_BITS_DEF          = 32;

	// most results one item may cause
	localparam int RESULT_CAP = 16;
	localparam int PASS_W     = $clog2(RESULT_CAP + 1);

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_LOOKUP = 3'd1;
	localparam logic [2:0] OP_FORGET = 3'd2;
	localparam logic [2:0] OP_LIST   = 3'd3;
	localparam logic [2:0] OP_TOP    = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISS     = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_SRC_FULL = 2'd3;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] word_hash;
		logic [31:0] source_id;
		logic [4:0]  top_count;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [31:0] occ_count;
		logic [31:0] item_value;
		logic [63:0] total_words;
		logic [8:0]  entries_used;
		logic        last;
	} out_item_t;

	typedef enum logic [4:0] {
		C_NOP,
		C_LOAD,
		C_SCAN_RD,
		C_SCAN_CMP,
		C_OUT_MISS,
		C_INS_NEW,
		C_INC,
		C_SRC_RD,
		C_SRC_CMP,
		C_APPEND,
		C_OUT_LOOK,
		C_FWD_INIT,
		C_FWD_RD,
		C_FWD_WR,
		C_FS_RD,
		C_FS_WR,
		C_FWD_NEXT,
		C_FWD_END,
		C_OUT_LEMPTY,
		C_LIST_OUT,
		C_TOP_INIT,
		C_TOP_CMP,
		C_TOP_OUT
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       used_zero;
		logic       hit;
		logic       scan_last;
		logic       found;
		logic       src_hit;
		logic       src_last;
		logic       fill_zero;
		logic       fs_done;
		logic       list_last;
		logic       top_last;
		logic       out_free;
	} dp_status_t;

endpackage

[design/wcpt_datapath.sv]
// table memories, scan registers and result register of the posting table
module wcpt_datapath #(
	parameter int TABLE_DEPTH       = wcpt_pkg::TABLE_DEPTH_DEF,
	parameter int SOURCES_PER_ENTRY = wcpt_pkg::SOURCES_PER_ENTRY_DEF,
	parameter int TOP_LIMIT         = wcpt_pkg::TOP_LIMIT_DEF,
	parameter int KEY_BITS          = wcpt_pkg::KEY_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wcpt_pkg::in_item_t   in_data,
	input  wcpt_pkg::dp_cmd_t    cmd,
	output wcpt_pkg::dp_status_t stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output wcpt_pkg::out_item_t  out_data
);
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int UW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = (SOURCES_PER_ENTRY > 1) ? $clog2(SOURCES_PER_ENTRY) : 1;
	localparam int FW = $clog2(SOURCES_PER_ENTRY + 1);
	localparam int SD = TABLE_DEPTH << SW;
	localparam int AW = IW + SW;
	localparam int PW = wcpt_pkg::PASS_W;

	logic [KEY_BITS-1:0] key_mem [TABLE_DEPTH];
	logic [31:0]         cnt_mem [TABLE_DEPTH];
	logic [FW-1:0]       fill_mem [TABLE_DEPTH];
	logic [31:0]         src_mem [SD];

	logic [KEY_BITS-1:0] key_rd;
	logic [31:0]         cnt_rd;
	logic [FW-1:0]       fill_rd;
	logic [31:0]         src_rd;

	logic [2:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [31:0]         src_q;
	logic [4:0]          want_q;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       ent_q;
	logic                found_q;
	logic [31:0]         cnt_q;
	logic [FW-1:0]       fill_q;
	logic [FW-1:0]       j_q;
	logic                dup_q;
	logic [PW-1:0]       p_q;
	logic                best_v_q;
	logic [IW-1:0]       best_idx_q;
	logic [31:0]         best_cnt_q;
	logic [KEY_BITS-1:0] best_key_q;
	logic [IW-1:0]       prev_idx_q;
	logic [31:0]         prev_cnt_q;
	logic [UW-1:0]       used_q;
	logic [63:0]         total_q;
	logic                out_valid_q;
	wcpt_pkg::out_item_t out_q;

	logic [KEY_BITS+31:0] hash_ext;
	logic [KEY_BITS+31:0] best_ext;
	logic [KEY_BITS-1:0]  key_in;
	logic [IW-1:0]        rd_idx;
	logic [AW-1:0]        src_ra;
	logic [IW-1:0]        wr_idx;
	logic [AW-1:0]        src_wa;
	logic                 key_we, cnt_we, fill_we, src_we;
	logic [KEY_BITS-1:0]  key_wd;
	logic [31:0]          cnt_wd;
	logic [FW-1:0]        fill_wd;
	logic [31:0]          src_wd;
	logic                 full;
	logic                 src_room;
	logic [31:0]          cnt_inc;
	logic [PW-1:0]        k_w;
	logic                 eligible;
	logic                 better;
	logic                 out_load;
	wcpt_pkg::out_item_t  out_d;
	logic [UW-1:0]        used_next;
	logic [UW+8:0]        used_ext;

	assign hash_ext = {{KEY_BITS{1'b0}}, in_data.word_hash};
	assign key_in   = hash_ext[KEY_BITS-1:0];
	assign best_ext = {32'd0, best_key_q};
	assign full     = (used_q >= UW'(TABLE_DEPTH));
	assign src_room = (fill_q < FW'(SOURCES_PER_ENTRY));
	assign cnt_inc  = (cnt_q == '1) ? cnt_q : cnt_q + 32'd1;

	// number of top entries this item gets: its request (zero counts as one), capped by the limits and the entries used
	always_comb begin
		k_w = (want_q == 5'd0) ? PW'(1) : PW'(want_q);
		if (32'(k_w) > 32'(TOP_LIMIT))
			k_w = PW'(TOP_LIMIT);
		if (32'(k_w) > 32'(wcpt_pkg::RESULT_CAP))
			k_w = PW'(wcpt_pkg::RESULT_CAP);
		if (32'(k_w) > 32'(used_q))
			k_w = PW'(used_q);
	end

	// next in order after the previous pick: lower count, or same count later
	assign eligible = (p_q == '0) || (cnt_rd < prev_cnt_q)
		|| ((cnt_rd == prev_cnt_q) && (idx_q > prev_idx_q));
	assign better = !best_v_q || (cnt_rd > best_cnt_q);

	always_comb begin
		rd_idx = idx_q;
		src_ra = {ent_q, j_q[SW-1:0]};
		if (cmd == wcpt_pkg::C_FWD_RD)
			rd_idx = idx_q + 1'b1;
		if (cmd == wcpt_pkg::C_FS_RD)
			src_ra = {idx_q + 1'b1, j_q[SW-1:0]};
	end

	always_comb begin
		key_we  = 1'b0;
		cnt_we  = 1'b0;
		fill_we = 1'b0;
		src_we  = 1'b0;
		wr_idx  = idx_q;
		src_wa  = {idx_q, j_q[SW-1:0]};
		key_wd  = key_rd;
		cnt_wd  = cnt_rd;
		fill_wd = fill_rd;
		src_wd  = src_rd;
		case (cmd)
			wcpt_pkg::C_INS_NEW: begin
				wr_idx = used_q[IW-1:0];
				src_wa = {used_q[IW-1:0], {SW{1'b0}}};
				key_wd = key_q;
				cnt_wd = 32'd1;
				fill_wd = FW'(1);
				src_wd = src_q;
				key_we = !full;
				cnt_we = !full;
				fill_we = !full;
				src_we = !full;
			end
			wcpt_pkg::C_INC: begin
				wr_idx = ent_q;
				cnt_wd = cnt_inc;
				cnt_we = 1'b1;
			end
			wcpt_pkg::C_APPEND: begin
				wr_idx = ent_q;
				src_wa = {ent_q, fill_q[SW-1:0]};
				fill_wd = fill_q + 1'b1;
				src_wd = src_q;
				fill_we = !dup_q && src_room;
				src_we = !dup_q && src_room;
			end
			wcpt_pkg::C_FWD_WR: begin
				key_we = 1'b1;
				cnt_we = 1'b1;
				fill_we = 1'b1;
			end
			wcpt_pkg::C_FS_WR: begin
				src_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[wr_idx] <= key_wd;
		key_rd <= key_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[wr_idx] <= cnt_wd;
		cnt_rd <= cnt_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (fill_we)
			fill_mem[wr_idx] <= fill_wd;
		fill_rd <= fill_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (src_we)
			src_mem[src_wa] <= src_wd;
		src_rd <= src_mem[src_ra];
	end

	always_comb begin
		out_load = 1'b0;
		used_next = used_q;
		out_d.status = wcpt_pkg::ST_OK;
		out_d.found = 1'b1;
		out_d.occ_count = cnt_q;
		out_d.item_value = 32'd0;
		out_d.last = 1'b1;
		case (cmd)
			wcpt_pkg::C_OUT_MISS: begin
				out_load = 1'b1;
				out_d.status = wcpt_pkg::ST_MISS;
				out_d.found = 1'b0;
				out_d.occ_count = 32'd0;
			end
			wcpt_pkg::C_INS_NEW: begin
				out_load = 1'b1;
				if (full) begin
					out_d.status = wcpt_pkg::ST_FULL;
					out_d.found = 1'b0;
					out_d.occ_count = 32'd0;
				end else begin
					out_d.occ_count = 32'd1;
					used_next = used_q + 1'b1;
				end
			end
			wcpt_pkg::C_APPEND: begin
				out_load = 1'b1;
				if (!dup_q && !src_room)
					out_d.status = wcpt_pkg::ST_SRC_FULL;
			end
			wcpt_pkg::C_OUT_LOOK: begin
				out_load = 1'b1;
			end
			wcpt_pkg::C_FWD_END: begin
				out_load = 1'b1;
				used_next = used_q - 1'b1;
			end
			wcpt_pkg::C_OUT_LEMPTY: begin
				out_load = 1'b1;
				out_d.status = wcpt_pkg::ST_MISS;
			end
			wcpt_pkg::C_LIST_OUT: begin
				out_load = 1'b1;
				out_d.item_value = src_rd;
				out_d.last = stat.list_last;
			end
			wcpt_pkg::C_TOP_OUT: begin
				out_load = 1'b1;
				out_d.occ_count = best_cnt_q;
				out_d.item_value = best_ext[31:0];
				out_d.last = stat.top_last;
			end
			default: begin
			end
		endcase
		used_ext = {9'd0, used_next};
		out_d.total_words = total_q;
		out_d.entries_used = used_ext[8:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			used_q <= used_next;
			if (cmd == wcpt_pkg::C_LOAD && in_data.op == wcpt_pkg::OP_INSERT
					&& total_q != '1)
				total_q <= total_q + 64'd1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= out_d;
		case (cmd)
			wcpt_pkg::C_LOAD: begin
				op_q <= in_data.op;
				key_q <= key_in;
				src_q <= in_data.source_id;
				want_q <= in_data.top_count;
				idx_q <= '0;
				found_q <= 1'b0;
				j_q <= '0;
				dup_q <= 1'b0;
				p_q <= '0;
			end
			wcpt_pkg::C_SCAN_CMP: begin
				if (stat.hit) begin
					found_q <= 1'b1;
					ent_q <= idx_q;
					cnt_q <= cnt_rd;
					fill_q <= fill_rd;
				end
				idx_q <= idx_q + 1'b1;
			end
			wcpt_pkg::C_INC: cnt_q <= cnt_inc;
			wcpt_pkg::C_SRC_CMP: begin
				if (stat.src_hit)
					dup_q <= 1'b1;
				j_q <= j_q + 1'b1;
			end
			wcpt_pkg::C_FWD_INIT: idx_q <= ent_q;
			wcpt_pkg::C_FWD_WR: begin
				fill_q <= fill_rd;
				j_q <= '0;
			end
			wcpt_pkg::C_FS_WR: j_q <= j_q + 1'b1;
			wcpt_pkg::C_FWD_NEXT: idx_q <= idx_q + 1'b1;
			wcpt_pkg::C_LIST_OUT: j_q <= j_q + 1'b1;
			wcpt_pkg::C_TOP_INIT: begin
				idx_q <= '0;
				best_v_q <= 1'b0;
			end
			wcpt_pkg::C_TOP_CMP: begin
				if (eligible && better) begin
					best_v_q <= 1'b1;
					best_idx_q <= idx_q;
					best_cnt_q <= cnt_rd;
					best_key_q <= key_rd;
				end
				idx_q <= idx_q + 1'b1;
			end
			wcpt_pkg::C_TOP_OUT: begin
				prev_idx_q <= best_idx_q;
				prev_cnt_q <= best_cnt_q;
				p_q <= p_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign stat.op        = op_q;
	assign stat.used_zero = (used_q == '0);
	assign stat.hit       = (key_rd == key_q);
	assign stat.scan_last = ((UW'(idx_q) + UW'(1)) >= used_q);
	assign stat.found     = found_q;
	assign stat.src_hit   = (src_rd == src_q);
	assign stat.src_last  = ((j_q + 1'b1) >= fill_q);
	assign stat.fill_zero = (fill_q == '0);
	assign stat.fs_done   = (j_q >= fill_q);
	assign stat.list_last = ((32'(j_q) + 32'd1) >= ((32'(fill_q) > 32'(wcpt_pkg::RESULT_CAP))
		? 32'(wcpt_pkg::RESULT_CAP) : 32'(fill_q)));
	assign stat.top_last  = ((32'(p_q) + 32'd1) >= 32'(k_w));
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[design/wcpt_ctrl.sv]
// sequencer that steps the posting table datapath through each operation
module wcpt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  wcpt_pkg::dp_status_t stat,
	output wcpt_pkg::dp_cmd_t    cmd
);
	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_RD, S_CMP, S_DECIDE, S_MISS, S_NEW, S_INC,
		S_SRD, S_SCMP, S_APPEND, S_LOOK, S_FCHK, S_FRD, S_FWR, S_FSRD,
		S_FSWR, S_FEND, S_LEMPTY, S_LRD, S_LOUT, S_TINIT, S_TRD, S_TCMP,
		S_TOUT
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = wcpt_pkg::C_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd = wcpt_pkg::C_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.op) inside
					wcpt_pkg::OP_TOP:
						state_d = stat.used_zero ? S_MISS : S_TINIT;
					wcpt_pkg::OP_INSERT, wcpt_pkg::OP_LOOKUP, wcpt_pkg::OP_FORGET,
					wcpt_pkg::OP_LIST:
						state_d = stat.used_zero ? S_DECIDE : S_RD;
					default: state_d = S_MISS;
				endcase
			end
			S_RD: begin
				cmd = wcpt_pkg::C_SCAN_RD;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd = wcpt_pkg::C_SCAN_CMP;
				state_d = (stat.hit || stat.scan_last) ? S_DECIDE : S_RD;
			end
			S_DECIDE: begin
				unique case (stat.op) inside
					wcpt_pkg::OP_INSERT: state_d = stat.found ? S_INC : S_NEW;
					wcpt_pkg::OP_LOOKUP: state_d = stat.found ? S_LOOK : S_MISS;
					wcpt_pkg::OP_FORGET: begin
						if (stat.found) begin
							cmd = wcpt_pkg::C_FWD_INIT;
							state_d = S_FCHK;
						end else begin
							state_d = S_MISS;
						end
					end
					wcpt_pkg::OP_LIST: begin
						if (!stat.found)
							state_d = S_MISS;
						else
							state_d = stat.fill_zero ? S_LEMPTY : S_LRD;
					end
					default: state_d = S_MISS;
				endcase
			end
			S_MISS: begin
				if (stat.out_free) begin
					cmd = wcpt_pkg::C_OUT_MISS;
					state_d = S_IDLE;
				end
			end
			S_NEW: begin
				if (stat.out_free) begin
					cmd = wcpt_pkg::C_INS_NEW;
					state_d = S_IDLE;
				end
			end
			S_INC: begin
				cmd = wcpt_pkg::C_INC;
				state_d = stat.fill_zero ? S_APPEND : S_SRD;
			end
			S_SRD: begin
				cmd = wcpt_pkg::C_SRC_RD;
				state_d = S_SCMP;
			end
			S_SCMP: begin
				cmd = wcpt_pkg::C_SRC_CMP;
				state_d = (stat.src_hit || stat.src_last) ? S_APPEND : S_SRD;
			end
			S_APPEND: begin
				if (stat.out_free) begin
					cmd = wcpt_pkg::C_APPEND;
					state_d = S_IDLE;
				end
			end
			S_LOOK: begin
				if (stat.out_free) begin
					cmd = wcpt_pkg::C_OUT_LOOK;
					state_d = S_IDLE;
				end
			end
			S_FCHK: state_d = stat.scan_last ? S_FEND : S_FRD;
			S_FRD: begin
				cmd = wcpt_pkg::C_FWD_RD;
				state_d = S_FWR;
			end
			S_FWR: begin
				cmd = wcpt_pkg::C_FWD_WR;
				state_d = S_FSRD;
			end
			S_FSRD: begin
				if (stat.fs_done) begin
					cmd = wcpt_pkg::C_FWD_NEXT;
					state_d = S_FCHK;
				end else begin
					cmd = wcpt_pkg::C_FS_RD;
					state_d = S_FSWR;
				end
			end
			S_FSWR: begin
				cmd = wcpt_pkg::C_FS_WR;
				state_d = S_FSRD;
			end
			S_FEND: begin
				if (stat.out_free) begin
					cmd = wcpt_pkg::C_FWD_END;
					state_d = S_IDLE;
				end
			end
			S_LEMPTY: begin
				if (stat.out_free) begin
					cmd = wcpt_pkg::C_OUT_LEMPTY;
					state_d = S_IDLE;
				end
			end
			S_LRD: begin
				cmd = wcpt_pkg::C_SRC_RD;
				state_d = S_LOUT;
			end
			S_LOUT: begin
				if (stat.out_free) begin
					cmd = wcpt_pkg::C_LIST_OUT;
					state_d = stat.list_last ? S_IDLE : S_LRD;
				end
			end
			S_TINIT: begin
				cmd = wcpt_pkg::C_TOP_INIT;
				state_d = S_TRD;
			end
			S_TRD: begin
				cmd = wcpt_pkg::C_SCAN_RD;
				state_d = S_TCMP;
			end
			S_TCMP: begin
				cmd = wcpt_pkg::C_TOP_CMP;
				state_d = stat.scan_last ? S_TOUT : S_TRD;
			end
			S_TOUT: begin
				if (stat.out_free) begin
					cmd = wcpt_pkg::C_TOP_OUT;
					state_d = stat.top_last ? S_IDLE : S_TINIT;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

[design/word_count_posting_table.sv]
// top level of the word count posting table
// One item is taken at a time; the block is ready again once its last result
// sits in the output register. Finding a hash reads the table in order, one
// entry held at a time. An insert of a known hash then reads the source ids
// already held, a forget copies every later entry and its ids down by one, a
// list reads each id up to RESULT_CAP, and top entries takes k passes over all
// entries held. All cost is set by the single read port of each table memory.
module word_count_posting_table #(
	parameter int TABLE_DEPTH       = wcpt_pkg::TABLE_DEPTH_DEF,
	parameter int SOURCES_PER_ENTRY = wcpt_pkg::SOURCES_PER_ENTRY_DEF,
	parameter int TOP_LIMIT         = wcpt_pkg::TOP_LIMIT_DEF,
	parameter int KEY_BITS          = wcpt_pkg::KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wcpt_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output wcpt_pkg::out_item_t out_data
);
	wcpt_pkg::dp_cmd_t    cmd;
	wcpt_pkg::dp_status_t stat;

	wcpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	wcpt_datapath #(
		.TABLE_DEPTH       (TABLE_DEPTH),
		.SOURCES_PER_ENTRY (SOURCES_PER_ENTRY),
		.TOP_LIMIT         (TOP_LIMIT),
		.KEY_BITS          (KEY_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[design/wcpt_checker.sv]
// port checks for the word count posting table and their binding
module wcpt_checker #(
	parameter int TABLE_DEPTH = wcpt_pkg::TABLE_DEPTH_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input wcpt_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input wcpt_pkg::out_item_t out_data
);
	// a waiting input item holds until its transfer
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input item changed while waiting");

	// a stalled result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(out_data.entries_used) <= 32'(TABLE_DEPTH))
		else $error("entries_used beyond table depth");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> out_data.occ_count == 32'd0
			&& out_data.item_value == 32'd0)
		else $error("missing entry reports data");

	a_srcfull_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == wcpt_pkg::ST_SRC_FULL |-> out_data.found)
		else $error("source list full without entry");

endmodule

bind word_count_posting_table wcpt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_wcpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

[sim/tb_word_count_posting_table.sv]
// self-checking testbench for the word count posting table
`timescale 1ns / 100ps

module tb_word_count_posting_table;

	localparam int DEPTH = 256;
	localparam int SRCS  = 16;
	localparam int TOPL  = 16;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	wcpt_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_ready;
	wcpt_pkg::out_item_t out_data;

	word_count_posting_table dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// shadow of the table
	logic [31:0] tbl_key [DEPTH];
	logic [31:0] tbl_cnt [DEPTH];
	logic [31:0] tbl_src [DEPTH][SRCS];
	int          tbl_fill [DEPTH];
	int          tbl_used;
	logic [63:0] word_total;

	wcpt_pkg::out_item_t expected_q[$];
	int                  fail_cnt;
	logic                stall_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int locate(logic [31:0] key);
		for (int i = 0; i < tbl_used; i++)
			if (tbl_key[i] == key) return i;
		return -1;
	endfunction

	function automatic void push_result(logic [1:0] st, logic fnd, logic [31:0] cnt,
			logic [31:0] val, logic lst);
		wcpt_pkg::out_item_t r;
		r.status       = st;
		r.found        = fnd;
		r.occ_count    = cnt;
		r.item_value   = val;
		r.total_words  = word_total;
		r.entries_used = tbl_used[8:0];
		r.last         = lst;
		expected_q.push_back(r);
	endfunction

	function automatic void predict_posting(wcpt_pkg::in_item_t it);
		int e, n, k, best;
		bit taken [DEPTH];
		bit dup;
		e = locate(it.word_hash);
		case (it.op)
			wcpt_pkg::OP_INSERT: begin
				if (word_total != '1) word_total++;
				if (e < 0) begin
					if (tbl_used >= DEPTH) begin
						push_result(wcpt_pkg::ST_FULL, 1'b0, 0, 0, 1'b1);
					end else begin
						tbl_key[tbl_used]    = it.word_hash;
						tbl_cnt[tbl_used]    = 1;
						tbl_src[tbl_used][0] = it.source_id;
						tbl_fill[tbl_used]   = 1;
						tbl_used++;
						push_result(wcpt_pkg::ST_OK, 1'b1, 1, 0, 1'b1);
					end
				end else begin
					if (tbl_cnt[e] != '1) tbl_cnt[e]++;
					dup = 1'b0;
					for (int j = 0; j < tbl_fill[e]; j++)
						if (tbl_src[e][j] == it.source_id) dup = 1'b1;
					if (dup) begin
						push_result(wcpt_pkg::ST_OK, 1'b1, tbl_cnt[e], 0, 1'b1);
					end else if (tbl_fill[e] >= SRCS) begin
						push_result(wcpt_pkg::ST_SRC_FULL, 1'b1, tbl_cnt[e], 0, 1'b1);
					end else begin
						tbl_src[e][tbl_fill[e]] = it.source_id;
						tbl_fill[e]++;
						push_result(wcpt_pkg::ST_OK, 1'b1, tbl_cnt[e], 0, 1'b1);
					end
				end
			end
			wcpt_pkg::OP_LOOKUP, wcpt_pkg::OP_FORGET, wcpt_pkg::OP_LIST: begin
				if (e < 0) begin
					push_result(wcpt_pkg::ST_MISS, 1'b0, 0, 0, 1'b1);
				end else if (it.op == wcpt_pkg::OP_LOOKUP) begin
					push_result(wcpt_pkg::ST_OK, 1'b1, tbl_cnt[e], 0, 1'b1);
				end else if (it.op == wcpt_pkg::OP_FORGET) begin
					n = tbl_cnt[e];
					for (int i = e; i + 1 < tbl_used; i++) begin
						tbl_key[i]  = tbl_key[i+1];
						tbl_cnt[i]  = tbl_cnt[i+1];
						tbl_fill[i] = tbl_fill[i+1];
						tbl_src[i]  = tbl_src[i+1];
					end
					tbl_used--;
					push_result(wcpt_pkg::ST_OK, 1'b1, n, 0, 1'b1);
				end else begin
					n = tbl_fill[e] > wcpt_pkg::RESULT_CAP ? wcpt_pkg::RESULT_CAP : tbl_fill[e];
					if (n == 0) push_result(wcpt_pkg::ST_MISS, 1'b1, tbl_cnt[e], 0, 1'b1);
					for (int j = 0; j < n; j++)
						push_result(wcpt_pkg::ST_OK, 1'b1, tbl_cnt[e], tbl_src[e][j],
							j + 1 == n);
				end
			end
			wcpt_pkg::OP_TOP: begin
				k = (it.top_count == 0) ? 1 : int'(it.top_count);
				if (k > TOPL) k = TOPL;
				if (k > wcpt_pkg::RESULT_CAP) k = wcpt_pkg::RESULT_CAP;
				if (k > tbl_used) k = tbl_used;
				if (k == 0) push_result(wcpt_pkg::ST_MISS, 1'b0, 0, 0, 1'b1);
				for (int i = 0; i < DEPTH; i++) taken[i] = 1'b0;
				for (int j = 0; j < k; j++) begin
					best = -1;
					for (int i = 0; i < tbl_used; i++)
						if (!taken[i] && (best < 0 || tbl_cnt[i] > tbl_cnt[best]))
							best = i;
					taken[best] = 1'b1;
					push_result(wcpt_pkg::ST_OK, 1'b1, tbl_cnt[best], tbl_key[best],
						j + 1 == k);
				end
			end
			default: push_result(wcpt_pkg::ST_MISS, 1'b0, 0, 0, 1'b1);
		endcase
	endfunction

	// result side: random backpressure and comparison against the oldest expectation
	initial begin
		int g;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_on) begin
				g = gap_len();
				out_ready <= (g == 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		wcpt_pkg::out_item_t x;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("unexpected transfer on result channel");
				fail_cnt++;
			end else begin
				x = expected_q.pop_front();
				if (out_data.status !== x.status) begin
					$error("status exp %0d got %0d", x.status, out_data.status); fail_cnt++;
				end
				if (out_data.found !== x.found) begin
					$error("found exp %0d got %0d", x.found, out_data.found); fail_cnt++;
				end
				if (out_data.occ_count !== x.occ_count) begin
					$error("occ_count exp %0h got %0h", x.occ_count, out_data.occ_count);
					fail_cnt++;
				end
				if (out_data.item_value !== x.item_value) begin
					$error("item_value exp %0h got %0h", x.item_value, out_data.item_value);
					fail_cnt++;
				end
				if (out_data.total_words !== x.total_words) begin
					$error("total_words exp %0h got %0h", x.total_words, out_data.total_words);
					fail_cnt++;
				end
				if (out_data.entries_used !== x.entries_used) begin
					$error("entries_used exp %0d got %0d", x.entries_used,
						out_data.entries_used);
					fail_cnt++;
				end
				if (out_data.last !== x.last) begin
					$error("last exp %0d got %0d", x.last, out_data.last); fail_cnt++;
				end
			end
		end
	end

	// valid stays up after a transfer only when the next item follows at once
	task automatic send_item(logic [2:0] op, logic [31:0] hash, logic [31:0] src,
			logic [4:0] tc, bit idle = 1'b1);
		wcpt_pkg::in_item_t it;
		int g;
		g = idle ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		it.op = op; it.word_hash = hash; it.source_id = src; it.top_count = tc;
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		predict_posting(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_item(wcpt_pkg::OP_TOP, 0, 0, 5);
		send_item(wcpt_pkg::OP_LOOKUP, 32'h1234, 0, 0);
		send_item(wcpt_pkg::OP_FORGET, 32'h1234, 0, 0);
		send_item(wcpt_pkg::OP_LIST, 32'h1234, 0, 0);
		send_item(wcpt_pkg::OP_INSERT, 32'h0, 32'h0, 0);
		send_item(wcpt_pkg::OP_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 5'h1F);
		send_item(wcpt_pkg::OP_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
		send_item(wcpt_pkg::OP_INSERT, 32'h0, 32'h5555AAAA, 0);
		for (int j = 0; j < 17; j++)
			send_item(wcpt_pkg::OP_INSERT, 32'hA5A5A5A5, 32'h100 + j, 0, 1'b0);
		send_item(wcpt_pkg::OP_LIST, 32'hA5A5A5A5, 0, 0);
		send_item(wcpt_pkg::OP_LOOKUP, 32'h0, 0, 0);
		send_item(wcpt_pkg::OP_TOP, 0, 0, 0);
		send_item(wcpt_pkg::OP_TOP, 0, 0, 5'h1F);
		send_item(wcpt_pkg::OP_TOP, 0, 0, 5'd16);
		send_item(wcpt_pkg::OP_FORGET, 32'hFFFFFFFF, 0, 0);
		for (int op = 5; op < 8; op++) send_item(3'(op), 32'h0, 0, 0);
		drain();
	endtask

	task automatic test_random_ops();
		logic [31:0] pool [12];
		int r;
		for (int i = 0; i < 12; i++) pool[i] = $urandom();
		for (int n = 0; n < 186; n++) begin
			r = $urandom_range(0, 99);
			if (n == 93) drain();  // let every pending result come back first
			if (n > 130 && n < 150) stall_on = 1'b0;
			else stall_on = 1'b1;
			send_item(r < 50 ? wcpt_pkg::OP_INSERT : r < 62 ? wcpt_pkg::OP_LOOKUP :
				r < 72 ? wcpt_pkg::OP_FORGET : r < 84 ? wcpt_pkg::OP_LIST :
				r < 96 ? wcpt_pkg::OP_TOP : 3'($urandom_range(5, 7)),
				($urandom_range(0, 9) == 0) ? $urandom() : pool[$urandom_range(0, 11)],
				($urandom_range(0, 2) == 0) ? $urandom() : 32'($urandom_range(0, 20)),
				5'($urandom()));
		end
		drain();
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		fail_cnt = 0;
		tbl_used = 0;
		word_total = '0;
		stall_on = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_ops();
		repeat (50) @(posedge clk);
		if (fail_cnt == 0 && expected_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[sim.f]
design/wcpt_pkg.sv
design/wcpt_datapath.sv
design/wcpt_ctrl.sv
design/word_count_posting_table.sv
design/wcpt_checker.sv
sim/tb_word_count_posting_table.sv
